// ===== sv/bdw_pkg.sv =====
package bdw_pkg;

    localparam int GRID_CELLS = 9;
    localparam int DEGREE     = 3;
    localparam int ROW        = GRID_CELLS + DEGREE;
    localparam int STORE      = ROW * ROW;
    localparam int NB         = DEGREE + 1;
    // weights are spread over 4x4 banks by (row mod 4, col mod 4)
    localparam int BW         = (ROW + 3) / 4;
    localparam int BDEPTH     = BW * BW;
    localparam int BAW        = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

    localparam int WW   = 24;
    localparam int PXW  = 16;
    localparam int UW   = 29;
    localparam int KW   = UW - 16;
    localparam int IW   = KW + 1;
    localparam int BASW = 17;
    localparam int PPW  = 2 * BASW;
    localparam int PW   = WW + PPW + 1;
    localparam int SW   = PW + 4;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_POINT  = 1'b1;
    localparam logic CFG_X_SCALE = 1'b0;
    localparam logic CFG_Y_SCALE = 1'b1;

    typedef logic [BAW-1:0] baddr_t;
    typedef logic [NB-1:0][BASW-1:0] bvec_t;
    typedef logic [NB-1:0][NB-1:0][WW-1:0] wgrid_t;

    typedef struct packed {
        logic          en;
        logic          axis;
        logic [1:0]    brow;
        logic [1:0]    bcol;
        baddr_t        addr;
        logic [WW-1:0] value;
    } wr_req_t;

endpackage

// ===== sv/bdw_wstore.sv =====
module bdw_wstore (
    input  logic                              clk,
    input  logic                              en,
    input  bdw_pkg::wr_req_t                  wr,
    input  logic signed [bdw_pkg::KW-1:0]     kx,
    input  logic signed [bdw_pkg::KW-1:0]     ky,
    output bdw_pkg::wgrid_t                   wx,
    output bdw_pkg::wgrid_t                   wy
);
    import bdw_pkg::*;

    logic [WW-1:0] mem_x [4][4][BDEPTH];
    logic [WW-1:0] mem_y [4][4][BDEPTH];
    logic [WW-1:0] dx_reg [4][4];
    logic [WW-1:0] dy_reg [4][4];
    logic [1:0]    kxl_reg;
    logic [1:0]    kyl_reg;
    logic [NB-1:0] vx_reg;
    logic [NB-1:0] vx_next;
    logic [NB-1:0] vy_reg;
    logic [NB-1:0] vy_next;
    baddr_t        arow [4];
    baddr_t        acol [4];
    baddr_t        raddr [4][4];

    always_comb
    begin
        logic [1:0]           mr;
        logic [1:0]           mc;
        logic [IW-1:0]        ir;
        logic [IW-1:0]        ic;
        logic signed [IW-1:0] iy;
        logic signed [IW-1:0] ix;
        for (int b = 0; b < 4; b++)
        begin
            mr = 2'(b) - ky[1:0];
            mc = 2'(b) - kx[1:0];
            ir = IW'(ky) + IW'(mr);
            ic = IW'(kx) + IW'(mc);
            arow[b] = BAW'(ir[IW-1:2]);
            acol[b] = BAW'(ic[IW-1:2]);
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                raddr[r][c] = BAW'(arow[r] * BW + acol[c]);
            end
        end
        for (int m = 0; m < NB; m++)
        begin
            iy = IW'(ky) + IW'(m);
            ix = IW'(kx) + IW'(m);
            vy_next[m] = (iy >= 0) && (iy < ROW);
            vx_next[m] = (ix >= 0) && (ix < ROW);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    dx_reg[r][c] <= mem_x[r][c][raddr[r][c]];
                    dy_reg[r][c] <= mem_y[r][c][raddr[r][c]];
                end
            end
            kxl_reg <= kx[1:0];
            kyl_reg <= ky[1:0];
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            if (wr.en)
            begin
                if (wr.axis)
                    mem_y[wr.brow][wr.bcol][wr.addr] <= wr.value;
                else
                    mem_x[wr.brow][wr.bcol][wr.addr] <= wr.value;
            end
        end
    end

    // reorder banks into basis order, zero the taps that fall off the grid
    always_comb
    begin
        logic [1:0] rb;
        logic [1:0] cb;
        for (int my = 0; my < NB; my++)
        begin
            for (int mx = 0; mx < NB; mx++)
            begin
                rb = 2'(kyl_reg + 2'(my));
                cb = 2'(kxl_reg + 2'(mx));
                wx[my][mx] = (vy_reg[my] && vx_reg[mx]) ? dx_reg[rb][cb] : '0;
                wy[my][mx] = (vy_reg[my] && vx_reg[mx]) ? dy_reg[rb][cb] : '0;
            end
        end
    end

endmodule

// ===== sv/bdw_basis.sv =====
module bdw_basis (
    input  logic           clk,
    input  logic           en,
    input  logic [15:0]    t,
    output bdw_pkg::bvec_t b
);
    import bdw_pkg::*;

    localparam int NW = 54;
    localparam logic signed [NW-1:0] T3  = NW'(1) << 48;
    localparam logic signed [NW-1:0] RND3 = NW'(3) << 32;
    localparam logic signed [NW-1:0] T2  = NW'(1) << 32;
    localparam logic signed [NW-1:0] RND2 = NW'(1) << 16;

    logic [15:0] t1_reg;
    logic [31:0] sq1_reg;
    logic [15:0] t2_reg;
    logic [31:0] sq2_reg;
    logic [47:0] cu2_reg;
    bvec_t       b_reg;
    bvec_t       b_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t;
            sq1_reg <= 32'(t) * 32'(t);
            t2_reg  <= t1_reg;
            sq2_reg <= sq1_reg;
            cu2_reg <= 48'(sq1_reg) * 48'(t1_reg);
            b_reg   <= b_next;
        end
    end

    always_comb
    begin
        logic signed [NW-1:0] tt;
        logic signed [NW-1:0] sq;
        logic signed [NW-1:0] cu;
        logic signed [NW-1:0] num;
        logic [19:0]          xq;
        logic [39:0]          prod;
        int                   j;
        tt = NW'(t2_reg);
        sq = NW'(sq2_reg);
        cu = NW'(cu2_reg);
        for (int m = 0; m < NB; m++)
        begin
            j = DEGREE - m;
            num = '0;
            xq = '0;
            prod = '0;
            b_next[m] = '0;
            if (DEGREE == 3)
            begin
                case (j)
                    0:       num = cu;
                    1:       num = -3 * cu + 3 * (sq <<< 16) + 3 * (tt <<< 32) + T3;
                    2:       num = 3 * cu - 6 * (sq <<< 16) + 4 * T3;
                    default: num = T3 - 3 * (tt <<< 32) + 3 * (sq <<< 16) - cu;
                endcase
                // divide by 6 * 2^32: shift, then reciprocal of 6
                xq = 20'((num + RND3) >>> 32);
                prod = 40'(xq) * 40'(349526);
                b_next[m] = BASW'(prod >> 21);
            end
            else if (DEGREE == 2)
            begin
                case (j)
                    0:       num = sq;
                    1:       num = -2 * sq + 2 * (tt <<< 16) + T2;
                    default: num = T2 - 2 * (tt <<< 16) + sq;
                endcase
                b_next[m] = BASW'((num + RND2) >>> 17);
            end
            else
            begin
                case (j)
                    0:       b_next[m] = BASW'(t2_reg);
                    default: b_next[m] = BASW'(17'h10000 - 17'(t2_reg));
                endcase
            end
        end
    end

    assign b = b_reg;

endmodule

// ===== sv/bdw_mac.sv =====
module bdw_mac (
    input  logic                           clk,
    input  logic                           en,
    input  bdw_pkg::bvec_t                 bx,
    input  bdw_pkg::bvec_t                 by,
    input  bdw_pkg::wgrid_t                wx,
    input  bdw_pkg::wgrid_t                wy,
    output logic signed [bdw_pkg::SW-1:0]  sx,
    output logic signed [bdw_pkg::SW-1:0]  sy
);
    import bdw_pkg::*;

    wgrid_t               wxd1_reg;
    wgrid_t               wxd2_reg;
    wgrid_t               wxd3_reg;
    wgrid_t               wyd1_reg;
    wgrid_t               wyd2_reg;
    wgrid_t               wyd3_reg;
    logic [PPW-1:0]       pp_reg [NB][NB];
    logic signed [PW-1:0] prx_reg [NB][NB];
    logic signed [PW-1:0] pry_reg [NB][NB];
    logic signed [SW-1:0] partx_reg [NB];
    logic signed [SW-1:0] party_reg [NB];
    logic signed [SW-1:0] partx_next [NB];
    logic signed [SW-1:0] party_next [NB];
    logic signed [SW-1:0] sx_reg;
    logic signed [SW-1:0] sy_reg;
    logic signed [SW-1:0] sx_next;
    logic signed [SW-1:0] sy_next;

    always_comb
    begin
        sx_next = '0;
        sy_next = '0;
        for (int my = 0; my < NB; my++)
        begin
            partx_next[my] = '0;
            party_next[my] = '0;
            for (int mx = 0; mx < NB; mx++)
            begin
                partx_next[my] = partx_next[my] + SW'(prx_reg[my][mx]);
                party_next[my] = party_next[my] + SW'(pry_reg[my][mx]);
            end
            sx_next = sx_next + partx_reg[my];
            sy_next = sy_next + party_reg[my];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wxd1_reg <= wx;
            wxd2_reg <= wxd1_reg;
            wxd3_reg <= wxd2_reg;
            wyd1_reg <= wy;
            wyd2_reg <= wyd1_reg;
            wyd3_reg <= wyd2_reg;
            for (int my = 0; my < NB; my++)
            begin
                for (int mx = 0; mx < NB; mx++)
                begin
                    pp_reg[my][mx]  <= PPW'(bx[mx]) * PPW'(by[my]);
                    prx_reg[my][mx] <= $signed(wxd3_reg[my][mx])
                                       * $signed({1'b0, pp_reg[my][mx]});
                    pry_reg[my][mx] <= $signed(wyd3_reg[my][mx])
                                       * $signed({1'b0, pp_reg[my][mx]});
                end
                partx_reg[my] <= partx_next[my];
                party_reg[my] <= party_next[my];
            end
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign sx = sx_reg;
    assign sy = sy_reg;

endmodule

// ===== sv/bspline_displacement_warp_top.sv =====
// Warps points through a cubic B-spline displacement field held in two
// weight stores. Requests on s_* either write one weight (func 0) or warp one
// point (func 1); only point requests give a result on m_*. Weights live in
// 4x4 interleaved banks so all taps of a point are read in parallel, and the
// datapath is a nine-stage pipeline: one request per cycle while m_tready
// does not stall it. Weight writes take effect in pipeline order, so a point
// sees exactly the writes accepted before it. Scale registers must be written
// on the cfg port while no request is in flight; the block does not check it.
module bspline_displacement_warp_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // weight_index, weight_value, point_x, point_y
    input  logic [63:0] s_tdata,
    // func, weight_axis
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // warped_x, warped_y
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bdw_pkg::*;

    // reciprocal of the row length in Q.11, exact floor for 8-bit indexes
    localparam int ROW_RECIP = (2048 + ROW - 1) / ROW;

    logic                  en;
    logic [15:0]           x_scale_reg;
    logic [15:0]           y_scale_reg;
    logic [8:1]            v_reg;
    logic [8:1]            pt_reg;
    logic signed [PXW-1:0] px_reg [1:8];
    logic signed [PXW-1:0] py_reg [1:8];
    logic signed [UW-1:0]  ux_reg;
    logic signed [UW-1:0]  uy_reg;
    wr_req_t               wr_reg;
    wr_req_t               wr_next;
    logic                  out_valid_reg;
    logic [PXW-1:0]        out_x_reg;
    logic [PXW-1:0]        out_y_reg;
    logic signed [32:0]    prodx;
    logic signed [32:0]    prody;
    logic [7:0]            widx;
    logic [7:0]            wrow;
    logic [7:0]            wcol;
    wgrid_t                wx;
    wgrid_t                wy;
    bvec_t                 bx;
    bvec_t                 by;
    logic signed [SW-1:0]  sx;
    logic signed [SW-1:0]  sy;

    function automatic logic [PXW-1:0] round_add_sat(input logic signed [SW-1:0] s,
                                                     input logic signed [PXW-1:0] p);
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] v;
        r = (s + (SW'(1) <<< 39)) >>> 40;
        v = r + SW'(p);
        if (v > 32767)
            return 16'h7fff;
        else if (v < -32768)
            return 16'h8000;
        else
            return PXW'(v);
    endfunction

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg <= '0;
            y_scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_SCALE: x_scale_reg <= cfg_data;
                CFG_Y_SCALE: y_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        widx         = s_tdata[7:0];
        wrow         = 8'((16'(widx) * 16'(ROW_RECIP)) >> 11);
        wcol         = 8'(16'(widx) - 16'(wrow) * 16'(ROW));
        wr_next.en   = s_tvalid && (s_tuser[0] == FUNC_WRITE) && (widx < STORE);
        wr_next.axis = s_tuser[1];
        wr_next.brow = wrow[1:0];
        wr_next.bcol = wcol[1:0];
        wr_next.addr = BAW'((wrow >> 2) * BW + (wcol >> 2));
        wr_next.value = s_tdata[31:8];
        prodx = $signed(s_tdata[47:32]) * $signed({1'b0, x_scale_reg});
        prody = $signed(s_tdata[63:48]) * $signed({1'b0, y_scale_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            wr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[7:1], s_tvalid};
            wr_reg        <= wr_next;
            out_valid_reg <= v_reg[8] && (pt_reg[8] == FUNC_POINT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg      <= {pt_reg[7:1], s_tuser[0]};
            px_reg[1]   <= s_tdata[47:32];
            py_reg[1]   <= s_tdata[63:48];
            for (int k = 2; k <= 8; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
            end
            ux_reg      <= UW'(prodx >>> 4);
            uy_reg      <= UW'(prody >>> 4);
            out_x_reg   <= round_add_sat(sx, px_reg[8]);
            out_y_reg   <= round_add_sat(sy, py_reg[8]);
        end
    end

    bdw_wstore u_wstore (
        .clk (clk),
        .en  (en),
        .wr  (wr_reg),
        .kx  (ux_reg[UW-1:16]),
        .ky  (uy_reg[UW-1:16]),
        .wx  (wx),
        .wy  (wy)
    );

    bdw_basis u_basis_x (
        .clk (clk),
        .en  (en),
        .t   (ux_reg[15:0]),
        .b   (bx)
    );

    bdw_basis u_basis_y (
        .clk (clk),
        .en  (en),
        .t   (uy_reg[15:0]),
        .b   (by)
    );

    bdw_mac u_mac (
        .clk (clk),
        .en  (en),
        .bx  (bx),
        .by  (by),
        .wx  (wx),
        .wy  (wy),
        .sx  (sx),
        .sy  (sy)
    );

    a_out_from_point: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v_reg[8] && (pt_reg[8] == FUNC_POINT)))
        else $error("result without a point request");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v_reg[8] && (pt_reg[8] == FUNC_WRITE)) |=> !m_tvalid)
        else $error("weight write produced a result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg.en |-> v_reg[1] && (pt_reg[1] == FUNC_WRITE))
        else $error("weight write without write request");

endmodule
